// ===== design/pft_pkg.sv =====
// shared types and constants for the polygon fan triangulator
`default_nettype none

package pft_pkg;

   // default sizing of the face buffer and of one stored vertex index
   localparam int PFT_MAX_FACE_VERTICES = 64;
   localparam int PFT_INDEX_BITS        = 24;

   // fixed field widths of the channels and registers
   localparam int OPCODE_W      = 2;
   localparam int FIELD_W       = 32;
   localparam int CORNER_W      = 24;
   localparam int STATUS_W      = 2;
   localparam int POINT_COUNT_W = 25;
   localparam int INDEX_TOTAL_W = 27;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_HEADER  = 2'd0,
      OP_INDEX   = 2'd1,
      OP_RESTART = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TRIANGLE = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_STOPPED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_SEND
   } seq_state_type;

endpackage

`default_nettype wire

// ===== design/pft_req_if.sv =====
// input channel: face headers, vertex indices and restarts
`default_nettype none

interface pft_req_if import pft_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [FIELD_W-1:0] face_count;
   logic signed [FIELD_W-1:0] vertex_index;

   modport source (output valid, output opcode, output face_count, output vertex_index,
                   input ready);
   modport sink   (input valid, input opcode, input face_count, input vertex_index,
                   output ready);
endinterface

`default_nettype wire

// ===== design/pft_rsp_if.sv =====
// result channel: triangles and face status
`default_nettype none

interface pft_rsp_if import pft_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CORNER_W-1:0] corner_a;
   logic [CORNER_W-1:0] corner_b;
   logic [CORNER_W-1:0] corner_c;
   logic [STATUS_W-1:0] status;
   logic                last_of_face;

   modport source (output valid, output corner_a, output corner_b, output corner_c,
                   output status, output last_of_face, input ready);
   modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                   input status, input last_of_face, output ready);
endinterface

`default_nettype wire

// ===== design/polygon_fan_triangulator_core.sv =====
// a header or index transfer that yields a status result shows it in the next cycle
// a completed good face of n vertices passes through SEQ_READ into SEQ_SEND after its last index,
// then gives one triangle a cycle while the output is free (n-2 in all) from the single
// read port of the face store; the input is held off while the fan is read out, so no
// new transfer is taken until the last triangle of the face is loaded
// reset (synchronous) clears control state, output valid and config registers at once; no clearing pass,
// the face store holds no reset value and only entries written for the open face are read
`default_nettype none

module polygon_fan_triangulator_core import pft_pkg::*; #(
   parameter int MAX_FACE_VERTICES = PFT_MAX_FACE_VERTICES,
   parameter int INDEX_BITS        = PFT_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   pft_req_if.sink               req,
   pft_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CW = $clog2(MAX_FACE_VERTICES + 1);
   localparam int AW = (MAX_FACE_VERTICES > 1) ? $clog2(MAX_FACE_VERTICES) : 1;
   localparam logic [CW-1:0] FAN_START = CW'(2);
   localparam logic [CW-1:0] MIN_FAN   = CW'(3);
   localparam logic          CSR_POINT_COUNT = 1'b0;
   localparam logic          CSR_INDEX_TOTAL = 1'b1;

   // configuration registers
   logic [POINT_COUNT_W-1:0] point_count_ff;
   logic [INDEX_TOTAL_W-1:0] index_total_ff;

   // face control state
   seq_state_type            seq_state_ff, seq_state_in;
   logic [CW-1:0]            face_length_ff, face_length_in;
   logic [CW-1:0]            received_count_ff, received_count_in;
   logic                     face_good_ff, face_good_in;
   logic [INDEX_TOTAL_W-1:0] indices_used_ff, indices_used_in;
   logic                     face_open_ff, face_open_in;
   logic                     halted_ff, halted_in;
   logic [CW-1:0]            fan_ptr_ff, fan_ptr_in;

   // fan apex and trailing corner
   logic [INDEX_BITS-1:0]    apex_ff, apex_in;
   logic [INDEX_BITS-1:0]    prev_ff, prev_in;

   // face store
   logic [INDEX_BITS-1:0]    face_store [MAX_FACE_VERTICES];
   logic [INDEX_BITS-1:0]    rd_data_ff;
   logic                     store_we;
   logic [AW-1:0]            store_wa;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;

   // output register
   logic                     rsp_valid_ff;
   logic [INDEX_BITS-1:0]    corner_a_ff, corner_b_ff, corner_c_ff;
   status_type               status_ff;
   logic                     last_ff;
   logic                     load_en;
   logic [INDEX_BITS-1:0]    load_a, load_b, load_c;
   status_type               load_status;
   logic                     load_last;

   logic                     req_accept;
   logic                     out_free;
   logic                     cfg_write;

   // header checks
   logic                     hdr_neg;
   logic                     hdr_too_big;
   logic [CW-1:0]            hdr_len;
   logic [INDEX_TOTAL_W:0]   hdr_sum;
   logic                     hdr_bad;

   // index checks
   logic                     idx_bad;
   logic [INDEX_BITS-1:0]    idx_value;
   logic [CW-1:0]            rc_next;
   logic                     idx_done;

   // corner widening to the channel width
   logic [INDEX_BITS+CORNER_W-1:0] a_ext, b_ext, c_ext;

   // handshakes
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (seq_state_ff == SEQ_IDLE) && out_free;
   assign req_accept = req.valid && req.ready;

   // header range and budget checks
   assign hdr_neg     = req.face_count[FIELD_W-1];
   assign hdr_too_big = req.face_count[FIELD_W-2:0] > (FIELD_W-1)'(MAX_FACE_VERTICES);
   assign hdr_len     = req.face_count[CW-1:0];
   assign hdr_sum     = {1'b0, indices_used_ff} + (INDEX_TOTAL_W+1)'(hdr_len);
   assign hdr_bad     = hdr_neg || hdr_too_big || (hdr_sum > {1'b0, index_total_ff});

   // vertex index checks
   assign idx_bad   = req.vertex_index[FIELD_W-1]
                   || ($unsigned(req.vertex_index) >= FIELD_W'(point_count_ff))
                   || (|req.vertex_index[FIELD_W-1:INDEX_BITS]);
   assign idx_value = req.vertex_index[INDEX_BITS-1:0];
   assign rc_next   = received_count_ff + CW'(1);
   assign idx_done  = (rc_next == face_length_ff);

   // sequencer: next state, store access and output load
   always_comb begin
      seq_state_in      = seq_state_ff;
      face_length_in    = face_length_ff;
      received_count_in = received_count_ff;
      face_good_in      = face_good_ff;
      indices_used_in   = indices_used_ff;
      face_open_in      = face_open_ff;
      halted_in         = halted_ff;
      fan_ptr_in        = fan_ptr_ff;
      apex_in           = apex_ff;
      prev_in           = prev_ff;
      store_we          = 1'b0;
      store_wa          = received_count_ff[AW-1:0];
      rd_en             = 1'b0;
      rd_addr           = fan_ptr_ff[AW-1:0];
      load_en           = 1'b0;
      load_a            = '0;
      load_b            = '0;
      load_c            = '0;
      load_status       = ST_TRIANGLE;
      load_last         = 1'b1;

      unique case (seq_state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               unique case (opcode_type'(req.opcode))
                  OP_RESTART: begin
                     face_length_in    = '0;
                     received_count_in = '0;
                     face_good_in      = 1'b1;
                     indices_used_in   = '0;
                     face_open_in      = 1'b0;
                     halted_in         = 1'b0;
                  end
                  OP_HEADER: begin
                     if (!halted_ff) begin
                        face_open_in = 1'b0;
                        if (hdr_bad) begin
                           halted_in   = 1'b1;
                           load_en     = 1'b1;
                           load_status = ST_STOPPED;
                        end else begin
                           indices_used_in   = hdr_sum[INDEX_TOTAL_W-1:0];
                           face_length_in    = hdr_len;
                           received_count_in = '0;
                           face_good_in      = 1'b1;
                           face_open_in      = (hdr_len != '0);
                        end
                     end
                  end
                  OP_INDEX: begin
                     if (!halted_ff && face_open_ff) begin
                        store_we          = 1'b1;
                        received_count_in = rc_next;
                        face_good_in      = face_good_ff && !idx_bad;
                        if (received_count_ff == '0) begin
                           apex_in = idx_value;
                        end
                        if (received_count_ff == CW'(1)) begin
                           prev_in = idx_value;
                        end
                        // face complete: drop it, start the fan read-out, or just close a face of under three
                        if (idx_done) begin
                           face_open_in = 1'b0;
                           if (!face_good_in) begin
                              load_en     = 1'b1;
                              load_status = ST_DROPPED;
                           end else if (face_length_ff >= MIN_FAN) begin
                              fan_ptr_in   = FAN_START;
                              seq_state_in = SEQ_READ;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         SEQ_READ: begin
            rd_en        = 1'b1;
            fan_ptr_in   = fan_ptr_ff + CW'(1);
            seq_state_in = SEQ_SEND;
         end
         SEQ_SEND: begin
            // one triangle per free output slot, next corner read alongside
            if (out_free) begin
               load_en     = 1'b1;
               load_a      = apex_ff;
               load_b      = prev_ff;
               load_c      = rd_data_ff;
               load_status = ST_TRIANGLE;
               load_last   = (fan_ptr_ff == face_length_ff);
               prev_in     = rd_data_ff;
               if (load_last) begin
                  seq_state_in = SEQ_IDLE;
               end else begin
                  rd_en      = 1'b1;
                  fan_ptr_in = fan_ptr_ff + CW'(1);
               end
            end
         end
         default: seq_state_in = SEQ_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff      <= SEQ_IDLE;
         face_length_ff    <= '0;
         received_count_ff <= '0;
         face_good_ff      <= 1'b1;
         indices_used_ff   <= '0;
         face_open_ff      <= 1'b0;
         halted_ff         <= 1'b0;
         fan_ptr_ff        <= '0;
      end else begin
         seq_state_ff      <= seq_state_in;
         face_length_ff    <= face_length_in;
         received_count_ff <= received_count_in;
         face_good_ff      <= face_good_in;
         indices_used_ff   <= indices_used_in;
         face_open_ff      <= face_open_in;
         halted_ff         <= halted_in;
         fan_ptr_ff        <= fan_ptr_in;
      end
   end

   // apex and trailing corner
   always_ff @(posedge clock) begin
      apex_ff <= apex_in;
      prev_ff <= prev_in;
   end

   // face store, one write and one registered read; no overlap as input stalls on read-out
   always_ff @(posedge clock) begin
      if (store_we) begin
         face_store[store_wa] <= idx_value;
      end
      if (rd_en) begin
         rd_data_ff <= face_store[rd_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         corner_a_ff <= load_a;
         corner_b_ff <= load_b;
         corner_c_ff <= load_c;
         status_ff   <= load_status;
         last_ff     <= load_last;
      end
   end

   assign a_ext = {CORNER_W'(0), corner_a_ff};
   assign b_ext = {CORNER_W'(0), corner_b_ff};
   assign c_ext = {CORNER_W'(0), corner_c_ff};

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.corner_a     = a_ext[CORNER_W-1:0];
   assign rsp.corner_b     = b_ext[CORNER_W-1:0];
   assign rsp.corner_c     = c_ext[CORNER_W-1:0];
   assign rsp.status       = status_ff;
   assign rsp.last_of_face = last_ff;

   // register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         index_total_ff <= '0;
      end else if (cfg_write) begin
         unique case (paddr[2])
            CSR_POINT_COUNT: point_count_ff <= pwdata[POINT_COUNT_W-1:0];
            CSR_INDEX_TOTAL: index_total_ff <= pwdata[INDEX_TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_POINT_COUNT: prdata = CSR_DATA_W'(point_count_ff);
         CSR_INDEX_TOTAL: prdata = CSR_DATA_W'(index_total_ff);
         default:         prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   // a stop result always leaves the block halted
   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      load_en && (load_status == ST_STOPPED) |=> halted_ff)
      else $error("stop result without halt");

   // fan read-out only runs for faces of three or more, pointer inside the face
   a_fan_bounds: assert property (@(posedge clock) disable iff (reset)
      (seq_state_ff != SEQ_IDLE) |->
         (face_length_ff >= MIN_FAN) && (fan_ptr_ff <= face_length_ff))
      else $error("fan pointer outside face");

   // an open face never has all its indices already
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      face_open_ff |-> (received_count_ff < face_length_ff))
      else $error("open face with full count");

   // the last triangle of a fan returns the sequencer to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      load_en && (load_status == ST_TRIANGLE) && load_last |=> (seq_state_ff == SEQ_IDLE))
      else $error("fan did not end on last triangle");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/polygon_fan_triangulator_core_tb.sv =====
// self-checking testbench for the polygon fan triangulator core
`timescale 1ns / 1ps

module polygon_fan_triangulator_core_tb;
   import pft_pkg::*;

   // register byte addresses and the opcode the block leaves unused
   localparam logic [CSR_ADDR_W-1:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_TOTAL = 3'd4;
   localparam logic [OPCODE_W-1:0]   OP_SPARE        = 2'd3;
   localparam int                    RANDOM_ITEMS    = 150;

   typedef struct {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [FIELD_W-1:0] face_count;
      logic signed [FIELD_W-1:0] vertex_index;
   } mesh_item_t;

   typedef struct {
      logic [CORNER_W-1:0] corner_a;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_c;
      status_type          status;
      logic                last_of_face;
   } fan_result_t;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pft_req_if req_bus ();
   pft_rsp_if rsp_bus ();

   polygon_fan_triangulator_core uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // stimulus waiting to be sent and triangles still owed by the block
   mesh_item_t  pending_items[$];
   fan_result_t due_results[$];
   mesh_item_t  in_flight;

   // mirror of the block's face state and registers
   logic [CORNER_W-1:0]      face_buf [PFT_MAX_FACE_VERTICES];
   logic [6:0]               verts_expected;
   logic [6:0]               verts_seen;
   bit                       face_ok;
   bit                       face_active;
   bit                       stopped;
   logic [INDEX_TOTAL_W-1:0] indices_claimed;
   logic [POINT_COUNT_W-1:0] model_point_count;
   logic [INDEX_TOTAL_W-1:0] model_index_total;

   int mismatches;
   int items_queued;
   int items_accepted;
   int results_checked;
   int triangles_seen;
   int dropped_seen;
   int stops_seen;
   int settings_used;
   int burst_left;
   int gap_left;
   int hold_left;
   bit long_hold_done;
   int rsp_cycle;
   int rsp_mode;
   bit ready_next;
   fan_result_t due;

   // clock, 4 ns period
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   task automatic post_result(input logic [CORNER_W-1:0] a, input logic [CORNER_W-1:0] b,
                              input logic [CORNER_W-1:0] c, input status_type st,
                              input logic last);
      fan_result_t r;
      r.corner_a     = a;
      r.corner_b     = b;
      r.corner_c     = c;
      r.status       = st;
      r.last_of_face = last;
      due_results.insert(due_results.size(), r);
   endtask

   task automatic clear_mesh_state();
      verts_expected  = '0;
      verts_seen      = '0;
      face_ok         = 1'b1;
      indices_claimed = '0;
      face_active     = 1'b0;
      stopped         = 1'b0;
   endtask

   // works out the results one accepted transfer causes
   task automatic triangulate(input mesh_item_t it);
      longint     count;
      logic [31:0] u;
      bit          bad;
      int          t;
      if (it.opcode == OP_RESTART) begin
         clear_mesh_state();
         return;
      end
      if (stopped || it.opcode == OP_SPARE)
         return;
      if (it.opcode == OP_HEADER) begin
         count       = it.face_count;
         face_active = 1'b0;
         if (count < 0 || count > PFT_MAX_FACE_VERTICES ||
             longint'(indices_claimed) + count > longint'(model_index_total)) begin
            stopped = 1'b1;
            post_result('0, '0, '0, ST_STOPPED, 1'b1);
            return;
         end
         indices_claimed = indices_claimed + count[INDEX_TOTAL_W-1:0];
         verts_expected  = count[6:0];
         verts_seen      = '0;
         face_ok         = 1'b1;
         face_active     = (count > 0);
         return;
      end
      // vertex index
      if (!face_active)
         return;
      u   = it.vertex_index;
      bad = u[31] || u >= model_point_count ||
            longint'(u) > ((longint'(1) << PFT_INDEX_BITS) - 1);
      if (bad)
         face_ok = 1'b0;
      face_buf[verts_seen[5:0]] = u[CORNER_W-1:0];
      verts_seen++;
      if (verts_seen < verts_expected)
         return;
      face_active = 1'b0;
      if (!face_ok) begin
         post_result('0, '0, '0, ST_DROPPED, 1'b1);
         return;
      end
      for (t = 2; t < verts_expected; t++)
         post_result(face_buf[0], face_buf[t-1], face_buf[t], ST_TRIANGLE,
                     (t + 1 == verts_expected));
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            triangulate(in_flight);
            items_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else begin
               in_flight = pending_items.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.opcode       <= in_flight.opcode;
               req_bus.face_count   <= in_flight.face_count;
               req_bus.vertex_index <= in_flight.vertex_index;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: checks each result transfer and stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         rsp_cycle = 0;
         rsp_mode  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: status %0d corners 0x%0h 0x%0h 0x%0h",
                      rsp_bus.status, rsp_bus.corner_a, rsp_bus.corner_b, rsp_bus.corner_c);
               mismatches++;
            end else begin
               due = due_results.pop_front();
               check_field("corner_a", due.corner_a, rsp_bus.corner_a);
               check_field("corner_b", due.corner_b, rsp_bus.corner_b);
               check_field("corner_c", due.corner_c, rsp_bus.corner_c);
               check_field("status", due.status, rsp_bus.status);
               check_field("last_of_face", due.last_of_face, rsp_bus.last_of_face);
               case (due.status)
                  ST_TRIANGLE: triangles_seen++;
                  ST_DROPPED:  dropped_seen++;
                  default:     stops_seen++;
               endcase
            end
            results_checked++;
         end
         // one long hold-off once traffic is flowing, so the input backs up
         if (!long_hold_done && results_checked >= 40) begin
            long_hold_done = 1'b1;
            hold_left      = 400;
         end
         if (rsp_cycle % 48 == 0)
            rsp_mode = $urandom_range(0, 3);
         rsp_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (rsp_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = $urandom_range(0, 1);
               2:       ready_next = (rsp_cycle % 4 != 0);
               default: ready_next = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_bus.ready <= ready_next;
      end
   end

   task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [31:0] count,
                            input logic [31:0] index);
      mesh_item_t it;
      it.opcode       = op;
      it.face_count   = count;
      it.vertex_index = index;
      pending_items.insert(pending_items.size(), it);
      items_queued++;
   endtask

   task automatic push_header(input logic [31:0] count);
      push_item(OP_HEADER, count, $urandom);
   endtask

   task automatic push_index(input logic [31:0] index);
      push_item(OP_INDEX, $urandom, index);
   endtask

   function automatic logic [31:0] bad_index(input logic [POINT_COUNT_W-1:0] pc);
      case ($urandom_range(0, 2))
         0:       return $urandom | 32'h8000_0000;
         1:       return pc + $urandom_range(0, 7);
         default: return $urandom | 32'h0100_0000;
      endcase
   endfunction

   // one face with random content: mostly well formed, some bad or abandoned
   task automatic add_random_face(input int forced_size);
      int n;
      int k;
      int cut;
      int bad_at;
      int r;
      r = $urandom_range(0, 99);
      if (forced_size > 0)
         n = forced_size;
      else if (r < 5)
         n = $urandom_range(40, PFT_MAX_FACE_VERTICES);
      else if (r < 15)
         n = $urandom_range(0, 2);
      else
         n = $urandom_range(3, 9);
      bad_at = (n > 0 && $urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
      cut    = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n) : n;
      push_header(n);
      for (k = 0; k < cut; k++) begin
         if (k == bad_at || model_point_count == 0)
            push_index(bad_index(model_point_count));
         else
            push_index($urandom_range(0, int'(model_point_count) - 1));
      end
   endtask

   task automatic add_random_traffic(input int count);
      int stop_at;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         case ($urandom_range(0, 15))
            0: push_item(OP_RESTART, $urandom, $urandom);
            1: push_item(OP_SPARE, $urandom, $urandom);
            2: push_index($urandom);
            3: begin
               push_header($urandom);
               if ($urandom_range(0, 1) == 0)
                  push_item(OP_RESTART, $urandom, $urandom);
            end
            default: add_random_face(0);
         endcase
      end
   endtask

   // register write followed by a read back of the same register
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("register read back", data, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == CSR_POINT_COUNT)
         model_point_count = data[POINT_COUNT_W-1:0];
      else
         model_index_total = data[INDEX_TOTAL_W-1:0];
   endtask

   task automatic set_mesh_limits(input logic [31:0] points, input logic [31:0] total);
      csr_write(CSR_POINT_COUNT, points);
      csr_write(CSR_INDEX_TOTAL, total);
      settings_used++;
   endtask

   // stimulus pauses here until every queued item is sent and every owed result has come back
   task automatic wait_drained(input int settle);
      do
         @(posedge clock);
      while (pending_items.size() != 0 || req_bus.valid || due_results.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // run limit
   initial begin
      #4_000_000;
      $display("polygon_fan_triangulator_core regression: fail");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_HEADER;
      req_bus.face_count   = '0;
      req_bus.vertex_index = '0;
      rsp_bus.ready        = 1'b0;
      model_point_count    = '0;
      model_index_total    = '0;
      clear_mesh_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: an empty face fits, anything larger stops the block
      push_header(0);
      push_header(3);
      push_index(5);
      push_item(OP_RESTART, 0, 0);
      wait_drained(8);

      // widest limits: corner extremes, bad index, short faces, stray items
      set_mesh_limits(32'd16777216, 32'd67108864);
      push_header(3);
      push_index(0);
      push_index(32'd16777215);
      push_index(7);
      push_header(4);
      push_index(1);
      push_index(32'hFFFF_FFFF);
      push_index(2);
      push_index(3);
      push_header(2);
      push_index(4);
      push_index(5);
      push_index(8);
      push_item(OP_SPARE, $urandom, $urandom);
      // header while a face is open abandons it
      push_header(5);
      push_index(1);
      push_header(3);
      push_index(32'd16777216);
      push_index(1);
      push_index(2);
      push_header(PFT_MAX_FACE_VERTICES + 1);
      push_index(1);
      push_item(OP_RESTART, 0, 0);
      push_header(32'h8000_0000);
      push_item(OP_RESTART, 0, 0);
      wait_drained(8);

      // no valid points and a tight index budget: overrun and all-bad face
      set_mesh_limits(32'd0, 32'd4);
      push_header(3);
      push_header(2);
      push_item(OP_RESTART, 0, 0);
      push_header(3);
      push_index(0);
      push_index(0);
      push_index(0);
      wait_drained(8);

      // random phases over several register settings, one largest face first
      set_mesh_limits(32'd1000, 32'd4000);
      add_random_face(PFT_MAX_FACE_VERTICES);
      add_random_traffic(RANDOM_ITEMS / 3);
      wait_drained(8);

      set_mesh_limits(32'd5, 32'd600);
      add_random_traffic(RANDOM_ITEMS / 3);
      wait_drained(8);

      set_mesh_limits(32'd16777216, 32'd67108864);
      add_random_traffic(RANDOM_ITEMS / 3);
      wait_drained(80);

      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         mismatches++;
      end
      $display("covered %0d input transfers over %0d register settings, %0d results checked",
               items_accepted, settings_used, results_checked);
      $display("  %0d triangles, %0d dropped faces, %0d stops, long hold-off %0s",
               triangles_seen, dropped_seen, stops_seen, long_hold_done ? "seen" : "missed");
      if (mismatches == 0)
         $display("polygon_fan_triangulator_core regression: pass");
      else
         $display("polygon_fan_triangulator_core regression: fail");
      $finish;
   end

endmodule
